@@ design/rtcs_pkg.sv @@
// Shared constants for the round-trip clock offset sync block.
// Operation and status codes, register indexes, default sizes.
// No dependencies.
`timescale 1ns / 1ps

package rtcs_pkg;

  // default sizes handed to the top level
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int TIME_WIDTH_DEF  = 16;

  // fixed field widths
  localparam int ID_W      = 8;
  localparam int GAIN_W    = 8;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_DISCOVER = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLY    = 2'd1;
  localparam logic [OP_W-1:0] OP_CONVERGE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_KNOWN   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MUL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DIV = 1'b1;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_MUL_RST = 8'd1;
  localparam logic [GAIN_W-1:0] GAIN_DIV_RST = 8'd2;

endpackage

@@ design/round_trip_clock_offset_sync_top.sv @@
// Top level of the round-trip clock offset sync block: sequencer,
// neighbour table memory, offset arithmetic and configuration registers.
// Depends on rtcs_pkg and rtcs_div.
//
//  channel  ports                              handshake
//  -------  ---------------------------------  ---------------------------
//  input    in_operation .. in_local_time      start && !busy
//  result   out_status .. out_neighbor_count   out_valid, one cycle
//  config   cfg_index, cfg_data                cfg_valid && cfg_ready
//
// Discover and reply walk the table through the single memory read port, one
// entry a cycle, until the id matches or the entries run out.
// Converge walks all entries, multiplies once and then runs the bit-serial
// divider, one bit a cycle.
// Reset clears the entry count but not the table memory; the table needs no clearing pass.
// The result is held for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module round_trip_clock_offset_sync_top
  import rtcs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
  localparam int SUM_W      = TIME_WIDTH + $clog2(TABLE_DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input transactions
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [ID_W-1:0]         in_neighbor_id,
  input  logic [TIME_WIDTH-1:0]   in_sender_time,
  input  logic [TIME_WIDTH-1:0]   in_echo_time,
  input  logic [TIME_WIDTH-1:0]   in_local_time,
  // result transactions
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [TIME_WIDTH-1:0] out_measured_offset,
  output logic signed [SUM_W-1:0] out_offset_sum,
  output logic [TIME_WIDTH-1:0]   out_corrected_time,
  output logic                    out_time_valid,
  output logic [CNT_W-1:0]        out_neighbor_count,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data
);

  localparam int TW     = TIME_WIDTH;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENT_W  = ID_W + TW;
  localparam int PROD_W = SUM_W + GAIN_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_OFF_HALF, S_OFF_FIN, S_SUM, S_MUL, S_DIV_GO, S_DIV_WAIT,
    S_FIN, S_NOP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [OP_W-1:0]          op_r,    op_nxt;
  logic [ID_W-1:0]          id_r,    id_nxt;
  logic [TW-1:0]            snd_r,   snd_nxt;
  logic [TW-1:0]            loc_r,   loc_nxt;
  logic [TW-1:0]            tmp_r,   tmp_nxt;
  logic [CNT_W-1:0]         idx_r,   idx_nxt;
  logic                     pend_r,  pend_nxt;
  logic [IDX_W-1:0]         pidx_r,  pidx_nxt;
  logic [IDX_W-1:0]         hidx_r,  hidx_nxt;
  logic [CNT_W-1:0]         cnt_r,   cnt_nxt;
  logic signed [SUM_W-1:0]  acc_r,   acc_nxt;
  logic signed [PROD_W-1:0] prod_r,  prod_nxt;
  logic                     neg_r,   neg_nxt;
  logic [GAIN_W-1:0]        gmul_r,  gmul_nxt;
  logic [GAIN_W-1:0]        gdiv_r,  gdiv_nxt;

  logic                     ov_r,    ov_nxt;
  logic [STAT_W-1:0]        ost_r,   ost_nxt;
  logic [TW-1:0]            omeas_r, omeas_nxt;
  logic [SUM_W-1:0]         osum_r,  osum_nxt;
  logic [TW-1:0]            ocorr_r, ocorr_nxt;
  logic                     otv_r,   otv_nxt;
  logic [CNT_W-1:0]         ocnt_r,  ocnt_nxt;

  // neighbour table: {id, offset} per entry
  logic [ENT_W-1:0]         mem [TABLE_DEPTH];
  logic [ENT_W-1:0]         rd_q_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wa;
  logic [ENT_W-1:0]         mem_wd;
  logic [ID_W-1:0]          rd_id;
  logic [TW-1:0]            rd_off;

  logic                     found;
  logic                     issue;
  logic                     fin;
  logic [STAT_W-1:0]        fin_st;
  logic [TW-1:0]            fin_meas;
  logic [SUM_W-1:0]         fin_sum;
  logic [TW-1:0]            fin_corr;
  logic                     fin_tv;
  logic [TW-1:0]            off_val;

  logic                     div_go;
  logic                     div_done;
  logic [PROD_W-1:0]        div_mag;
  logic [PROD_W-1:0]        div_quot;
  logic [GAIN_W-1:0]        div_d;

  assign rd_id  = rd_q_r[ENT_W-1 -: ID_W];
  assign rd_off = rd_q_r[TW-1:0];
  assign found  = pend_r && (rd_id == id_r);
  assign issue  = (idx_r < cnt_r);

  // divider operands: magnitude of the product, zero divisor taken as one
  assign div_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign div_d   = (gdiv_r == '0) ? GAIN_W'(1) : gdiv_r;

  rtcs_div #(
    .DIV_W (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_mag),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    id_nxt    = id_r;
    snd_nxt   = snd_r;
    loc_nxt   = loc_r;
    tmp_nxt   = tmp_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    hidx_nxt  = hidx_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    neg_nxt   = neg_r;
    gmul_nxt  = gmul_r;
    gdiv_nxt  = gdiv_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    omeas_nxt = omeas_r;
    osum_nxt  = osum_r;
    ocorr_nxt = ocorr_r;
    otv_nxt   = otv_r;
    ocnt_nxt  = ocnt_r;
    rd_addr   = idx_r[IDX_W-1:0];
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    div_go    = 1'b0;
    fin       = 1'b0;
    fin_st    = ST_DONE;
    fin_meas  = '0;
    fin_sum   = '0;
    fin_corr  = '0;
    fin_tv    = 1'b0;
    off_val   = loc_r - tmp_r;

    // configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GAIN_MUL: gmul_nxt = cfg_data;
        CFG_GAIN_DIV: gdiv_nxt = cfg_data;
        default:      gmul_nxt = gmul_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_operation;
          id_nxt   = in_neighbor_id;
          snd_nxt  = in_sender_time;
          loc_nxt  = in_local_time;
          tmp_nxt  = in_local_time - in_echo_time;   // round trip
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          acc_nxt  = '0;
          unique case (in_operation) inside
            OP_DISCOVER, OP_REPLY: state_nxt = S_SCAN;
            OP_CONVERGE:           state_nxt = S_SUM;
            default:               state_nxt = S_NOP;
          endcase
        end
      end

      // lookup: read one entry a cycle, compare it in the cycle after its read
      S_SCAN: begin
        if (issue) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (found || !issue) begin
          if (op_r == OP_DISCOVER) begin
            fin = 1'b1;
            if (found) begin
              fin_st = ST_KNOWN;
            end else if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
              fin_st = ST_FULL;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = cnt_r[IDX_W-1:0];
              mem_wd  = {id_r, {TW{1'b0}}};
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (found) begin
            hidx_nxt  = pidx_r;
            state_nxt = S_OFF_HALF;
          end else begin
            fin    = 1'b1;
            fin_st = ST_UNKNOWN;
          end
        end
      end

      // their time = sender + rtt/2
      S_OFF_HALF: begin
        tmp_nxt   = snd_r + (tmp_r >> 1);
        state_nxt = S_OFF_FIN;
      end

      // offset = local - their time, stored for the neighbour
      S_OFF_FIN: begin
        mem_we   = 1'b1;
        mem_wa   = hidx_r;
        mem_wd   = {id_r, off_val};
        fin      = 1'b1;
        fin_meas = off_val;
      end

      // accumulate every offset and clear it behind the read
      S_SUM: begin
        if (issue) begin
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[IDX_W-1:0];
          idx_nxt  = idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          acc_nxt = acc_r + SUM_W'($signed(rd_off));
          mem_we  = 1'b1;
          mem_wa  = pidx_r;
          mem_wd  = {rd_id, {TW{1'b0}}};
        end
        if (!issue) begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(acc_r) * PROD_W'($signed({1'b0, gmul_r}));
        state_nxt = S_DIV_GO;
      end

      S_DIV_GO: begin
        div_go    = 1'b1;
        neg_nxt   = prod_r[PROD_W-1];
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end

      // local - q, with the sign of the quotient folded into the add
      S_FIN: begin
        fin     = 1'b1;
        fin_sum = acc_r;
        fin_tv  = 1'b1;
        if (neg_r) begin
          fin_corr = loc_r + div_quot[TW-1:0];
        end else begin
          fin_corr = loc_r - div_quot[TW-1:0];
        end
      end

      S_NOP: begin
        fin = 1'b1;
      end

      default: state_nxt = S_IDLE;
    endcase

    // hand out the result transaction
    if (fin) begin
      ov_nxt    = 1'b1;
      ost_nxt   = fin_st;
      omeas_nxt = fin_meas;
      osum_nxt  = fin_sum;
      ocorr_nxt = fin_corr;
      otv_nxt   = fin_tv;
      ocnt_nxt  = cnt_nxt;
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      gmul_r  <= GAIN_MUL_RST;
      gdiv_r  <= GAIN_DIV_RST;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      gmul_r  <= gmul_nxt;
      gdiv_r  <= gdiv_nxt;
      ov_r    <= ov_nxt;
    end
    op_r    <= op_nxt;
    id_r    <= id_nxt;
    snd_r   <= snd_nxt;
    loc_r   <= loc_nxt;
    tmp_r   <= tmp_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    hidx_r  <= hidx_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    ost_r   <= ost_nxt;
    omeas_r <= omeas_nxt;
    osum_r  <= osum_nxt;
    ocorr_r <= ocorr_nxt;
    otv_r   <= otv_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_measured_offset = $signed(omeas_r);
  assign out_offset_sum      = $signed(osum_r);
  assign out_corrected_time  = ocorr_r;
  assign out_time_valid      = otv_r;
  assign out_neighbor_count  = ocnt_r;

  // table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("neighbour count beyond table depth");

  // an accepted transaction always takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction left the sequencer idle");

  // reported count matches the table while the result is shown
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (ocnt_r == cnt_r))
    else $error("result count differs from table count");

  // divider only completes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WAIT))
    else $error("divider finished outside its wait state");

  // an unknown neighbour never reports a measured offset
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (ost_r == ST_UNKNOWN)) |-> (omeas_r == '0) && !otv_r)
    else $error("unknown neighbour reported an offset");

endmodule

@@ design/rtcs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the gain division.
// Unsigned dividend of DIV_W bits over an 8-bit divisor.
// Depends on rtcs_pkg.
`timescale 1ns / 1ps

module rtcs_div
  import rtcs_pkg::*;
#(
  parameter int DIV_W = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [GAIN_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              run_r,  run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  q_r,    q_nxt;
  logic [GAIN_W-1:0] rem_r,  rem_nxt;
  logic [GAIN_W-1:0] d_r,    d_nxt;
  logic [GAIN_W:0]   trial;
  logic [GAIN_W:0]   diff;

  // one step: shift the next dividend bit into the remainder, try subtract
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    trial    = {rem_r, q_r[DIV_W-1]};
    diff     = trial - {1'b0, d_r};
    if (go) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_W'(DIV_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = diff[GAIN_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[GAIN_W-1:0];
        q_nxt   = {q_r[DIV_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ test/rtcs_sync_checker.sv @@
// Scoreboard for the round-trip clock offset sync block: watches the input,
// result and configuration channels, predicts every result and compares it.
// Depends on rtcs_pkg.
`timescale 1ns / 1ps

module rtcs_sync_checker
  import rtcs_pkg::*;
#(
  localparam int TW    = TIME_WIDTH_DEF,
  localparam int DEPTH = TABLE_DEPTH_DEF,
  localparam int SUM_W = TW + $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [ID_W-1:0]         in_neighbor_id,
  input  logic [TW-1:0]           in_sender_time,
  input  logic [TW-1:0]           in_echo_time,
  input  logic [TW-1:0]           in_local_time,
  input  logic                    out_valid,
  input  logic [STAT_W-1:0]       out_status,
  input  logic signed [TW-1:0]    out_measured_offset,
  input  logic signed [SUM_W-1:0] out_offset_sum,
  input  logic [TW-1:0]           out_corrected_time,
  input  logic                    out_time_valid,
  input  logic [CNT_W-1:0]        out_neighbor_count,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [GAIN_W-1:0]       cfg_data,
  output int                      fail_count,
  output int                      pending,
  output int                      results_checked
);

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [TW-1:0]    measured;
    logic signed [SUM_W-1:0] sum;
    logic [TW-1:0]           corrected;
    logic                    tvalid;
    logic [CNT_W-1:0]        count;
  } sync_result_t;

  // shadow of the neighbour table and gain registers
  logic [ID_W-1:0]      nb_id     [DEPTH];
  logic signed [TW-1:0] nb_offset [DEPTH];
  int                   nb_count;
  logic [GAIN_W-1:0]    gain_mul;
  logic [GAIN_W-1:0]    gain_div;

  sync_result_t expected_q[$];
  int n_fail    = 0;
  int n_checked = 0;
  int n_pending = 0;

  assign fail_count      = n_fail;
  assign pending         = n_pending;
  assign results_checked = n_checked;

  function automatic int find_neighbour(input logic [ID_W-1:0] id);
    for (int k = 0; k < nb_count; k++) begin
      if (nb_id[k] == id) return k;
    end
    return -1;
  endfunction

  // work out the result of one transaction and update the shadow state
  function automatic sync_result_t predict_sync(input logic [OP_W-1:0] op,
                                                input logic [ID_W-1:0] id,
                                                input logic [TW-1:0] snd,
                                                input logic [TW-1:0] ech,
                                                input logic [TW-1:0] loc);
    sync_result_t      r;
    int                pos;
    logic [TW-1:0]     rtt;
    logic [TW-1:0]     their;
    logic [TW-1:0]     off;
    longint            total;
    longint            scaled;
    logic [GAIN_W-1:0] div_eff;
    r = '0;
    total = 0;
    case (op)
      OP_DISCOVER: begin
        pos = find_neighbour(id);
        if (pos >= 0) begin
          r.status = ST_KNOWN;
        end else if (nb_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          nb_id[nb_count]     = id;
          nb_offset[nb_count] = '0;
          nb_count++;
        end
      end
      OP_REPLY: begin
        pos = find_neighbour(id);
        if (pos < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          // half the round trip is credited to the neighbour's clock
          rtt   = loc - ech;
          their = snd + (rtt >> 1);
          off   = loc - their;
          nb_offset[pos] = off;
          r.measured     = off;
        end
      end
      OP_CONVERGE: begin
        for (int k = 0; k < nb_count; k++) begin
          total += longint'(nb_offset[k]);
          nb_offset[k] = '0;
        end
        div_eff = (gain_div == '0) ? GAIN_W'(1) : gain_div;
        // signed division truncates toward zero
        scaled = (total * longint'(gain_mul)) / longint'(div_eff);
        r.sum       = total[SUM_W-1:0];
        r.corrected = loc - scaled[TW-1:0];
        r.tvalid    = 1'b1;
      end
      default: ;  // no operation: only the count is reported
    endcase
    r.count = CNT_W'(nb_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sync_result_t got;
    sync_result_t want;
    if (!rst_n) begin
      nb_count = 0;
      gain_mul = GAIN_MUL_RST;
      gain_div = GAIN_DIV_RST;
      expected_q.delete();
      n_pending <= 0;
    end else begin
      // results first: they belong to earlier transactions
      if (out_valid) begin
        got.status    = out_status;
        got.measured  = out_measured_offset;
        got.sum       = out_offset_sum;
        got.corrected = out_corrected_time;
        got.tvalid    = out_time_valid;
        got.count     = out_neighbor_count;
        if (expected_q.size() == 0) begin
          if (n_fail < 10)
            $display("[%0t] result with no transaction outstanding: st=%0d cnt=%0d",
                     $realtime, got.status, got.count);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got.status !== want.status || got.measured !== want.measured ||
              got.sum !== want.sum || got.corrected !== want.corrected ||
              got.tvalid !== want.tvalid || got.count !== want.count) begin
            if (n_fail < 10) begin
              $display("[%0t] result %0d mismatch, expected st=%0d off=%0d sum=%0d t=%0h tv=%0d cnt=%0d",
                       $realtime, n_checked, want.status, want.measured, want.sum,
                       want.corrected, want.tvalid, want.count);
              $display("    actual   st=%0d off=%0d sum=%0d t=%0h tv=%0d cnt=%0d",
                       got.status, got.measured, got.sum, got.corrected, got.tvalid,
                       got.count);
            end
            n_fail++;
          end
        end
      end
      // gain register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN_MUL: gain_mul = cfg_data;
          CFG_GAIN_DIV: gain_div = cfg_data;
          default: ;
        endcase
      end
      // accepted input transaction
      if (start && !busy)
        expected_q.push_back(predict_sync(in_operation, in_neighbor_id, in_sender_time,
                                          in_echo_time, in_local_time));
      n_pending <= expected_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the round-trip clock offset sync block: clock, reset,
// stimulus and verdict. Depends on rtcs_pkg, the block and rtcs_sync_checker.
`timescale 1ns / 1ps

module tb_top;
  import rtcs_pkg::*;

  localparam int TW    = TIME_WIDTH_DEF;
  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int SUM_W = TW + $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // the fourth operation code has no meaning; the block only reports the count
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         in_operation;
  logic [ID_W-1:0]         in_neighbor_id;
  logic [TW-1:0]           in_sender_time;
  logic [TW-1:0]           in_echo_time;
  logic [TW-1:0]           in_local_time;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic signed [TW-1:0]    out_measured_offset;
  logic signed [SUM_W-1:0] out_offset_sum;
  logic [TW-1:0]           out_corrected_time;
  logic                    out_time_valid;
  logic [CNT_W-1:0]        out_neighbor_count;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [GAIN_W-1:0]       cfg_data;
  int                      fail_count;
  int                      pending;
  int                      results_checked;

  // stimulus bookkeeping: ids the table should hold, per-operation counts
  bit              seen_id [256];
  logic [ID_W-1:0] known_ids[$];
  bit              quiet;
  int              n_disc, n_reply, n_conv, n_ign;
  int              cycle_count = 0;

  round_trip_clock_offset_sync_top i_dut (.*);
  rtcs_sync_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // present one transaction and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [TW-1:0] snd, input logic [TW-1:0] ech,
                           input logic [TW-1:0] loc);
    in_operation   <= op;
    in_neighbor_id <= id;
    in_sender_time <= snd;
    in_echo_time   <= ech;
    in_local_time  <= loc;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    case (op)
      OP_DISCOVER: n_disc++;
      OP_REPLY:    n_reply++;
      OP_CONVERGE: n_conv++;
      default:     n_ign++;
    endcase
    if (op == OP_DISCOVER && !seen_id[id] && known_ids.size() < DEPTH) begin
      seen_id[id] = 1'b1;
      known_ids.push_back(id);
    end
  endtask

  // random gap after a transaction: mostly none or short, now and then long
  task automatic idle_gap();
    int r;
    int g;
    if (quiet) return;
    r = $urandom_range(0, 99);
    if (r < 45)      g = 0;
    else if (r < 80) g = $urandom_range(1, 3);
    else if (r < 96) g = $urandom_range(4, 15);
    else             g = $urandom_range(30, 80);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has been seen
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] mul, input logic [GAIN_W-1:0] div);
    drain();
    cfg_index <= CFG_GAIN_MUL;
    cfg_data  <= mul;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_GAIN_DIV;
    cfg_data  <= div;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // an id the table holds with the given percent chance, otherwise any id
  function automatic logic [ID_W-1:0] pick_id(input int known_pct);
    if (known_ids.size() > 0 && $urandom_range(0, 99) < known_pct)
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
    return ID_W'($urandom_range(0, 255));
  endfunction

  task automatic random_items(input int n);
    int              r;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [TW-1:0]   loc;
    logic [TW-1:0]   ech;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30)      op = OP_DISCOVER;
      else if (r < 75) op = OP_REPLY;
      else if (r < 94) op = OP_CONVERGE;
      else             op = OP_IGNORED;
      id  = pick_id((op == OP_REPLY) ? 85 : 20);
      loc = TW'($urandom);
      // half the items carry a plausible round trip
      ech = $urandom_range(0, 1) ? TW'(loc - $urandom_range(0, 400)) : TW'($urandom);
      send_item(op, id, TW'($urandom), ech, loc);
      if ($urandom_range(0, 99) < 2) drain();
      else idle_gap();
    end
    quiet = 1'b0;
  endtask

  // grow the table to its depth, then knock on the door a few more times
  task automatic fill_table();
    logic [ID_W-1:0] id;
    while (known_ids.size() < DEPTH) begin
      send_item(OP_DISCOVER, ID_W'($urandom_range(0, 255)), TW'($urandom), TW'($urandom),
                TW'($urandom));
      idle_gap();
    end
    repeat (3) begin
      do id = ID_W'($urandom_range(0, 255)); while (seen_id[id]);
      send_item(OP_DISCOVER, id, TW'($urandom), TW'($urandom), TW'($urandom));
      idle_gap();
    end
  endtask

  // give every neighbour the same offset (zero round trip), then converge
  task automatic saturate(input logic [TW-1:0] off);
    logic [TW-1:0] loc;
    foreach (known_ids[k]) begin
      loc = TW'($urandom);
      send_item(OP_REPLY, known_ids[k], TW'(loc - off), loc, loc);
      idle_gap();
    end
    send_item(OP_CONVERGE, '0, '0, '0, TW'($urandom));
    idle_gap();
  endtask

  initial begin
    start          <= 1'b0;
    in_operation   <= OP_DISCOVER;
    in_neighbor_id <= '0;
    in_sender_time <= '0;
    in_echo_time   <= '0;
    in_local_time  <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_GAIN_MUL;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    quiet = 1'b0;
    n_disc = 0; n_reply = 0; n_conv = 0; n_ign = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, unknown reply, ignored code, known id, extremes
    send_item(OP_CONVERGE, '0, '0, '0, '0);                        idle_gap();
    send_item(OP_CONVERGE, '1, '1, '1, '1);                        idle_gap();
    send_item(OP_REPLY, 8'h5a, '1, '0, '1);                        idle_gap();
    send_item(OP_IGNORED, '1, '1, '1, '1);                         idle_gap();
    send_item(OP_IGNORED, '0, '0, '0, '0);                         idle_gap();
    send_item(OP_DISCOVER, 8'h00, '0, '0, '0);                     idle_gap();
    send_item(OP_DISCOVER, 8'hff, '1, '1, '1);                     idle_gap();
    send_item(OP_DISCOVER, 8'h00, '1, '0, '1);                     idle_gap();
    send_item(OP_REPLY, 8'h00, '0, '0, '0);                        idle_gap();
    send_item(OP_REPLY, 8'hff, '1, '0, '1);                        idle_gap();
    send_item(OP_REPLY, 8'h00, 16'h8000, '1, '0);                  idle_gap();
    send_item(OP_REPLY, 8'h80, 16'h1234, 16'h0100, 16'h0200);      idle_gap();
    send_item(OP_CONVERGE, '0, '0, '0, 16'h1234);                  idle_gap();
    send_item(OP_CONVERGE, '0, '0, '0, '1);                        idle_gap();
    send_item(OP_DISCOVER, 8'h80, '0, '0, '0);                     idle_gap();
    send_item(OP_DISCOVER, 8'h01, '0, '0, '0);                     idle_gap();
    send_item(OP_REPLY, 8'h01, 16'h1000, 16'h0100, 16'h0200);      idle_gap();
    send_item(OP_REPLY, 8'h80, '1, '1, '1);                        idle_gap();
    send_item(OP_REPLY, 8'hff, '0, '0, 16'h7fff);                  idle_gap();
    send_item(OP_CONVERGE, '0, '0, '0, '0);                        idle_gap();
    send_item(OP_REPLY, 8'h00, 16'h4000, 16'hfff0, 16'h0010);      idle_gap();
    send_item(OP_CONVERGE, '0, '0, '0, 16'h8000);

    // random phases across gain settings, extremes included
    set_gains(8'd0, 8'd1);
    random_items(120);
    set_gains(8'd255, 8'd255);
    random_items(120);
    set_gains(8'd1, 8'd255);
    random_items(120);
    set_gains(8'd37, 8'd0);
    random_items(80);
    set_gains(8'd255, 8'd1);
    random_items(120);
    fill_table();
    saturate(16'h8000);
    saturate(16'h7fff);
    set_gains(GAIN_W'($urandom_range(0, 255)), GAIN_W'($urandom_range(1, 255)));
    random_items(80);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d transactions (%0d discover, %0d reply, %0d converge, %0d ignored), %0d results checked, %0d failures",
             n_disc + n_reply + n_conv + n_ign, n_disc, n_reply, n_conv, n_ign,
             results_checked, fail_count);
    $display("Gains swept over multiplier 0..255 and divider 0..255; table filled and summed at both offset extremes");
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
